FILE: rtl/pstg_pkg.sv
// Shared constants, types and the quarter-wave sine table for the PCM sine tone generator.
package pstg_pkg;

   localparam int MAX_CHANNELS    = 8;
   localparam int TABLE_ADDR_BITS = 12;
   localparam int PHASE_BITS      = 32;

   localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ROM_ADDR_W  = TABLE_ADDR_BITS - 1;
   localparam int QUARTER     = 1 << (TABLE_ADDR_BITS - 2);
   localparam int HALF        = 1 << (TABLE_ADDR_BITS - 1);
   localparam int MAG_W       = 23;
   localparam int AMP_W       = 17;
   localparam int STEP_W      = 32;
   localparam int PERIOD_W    = 24;
   localparam int COUNT_W     = 4;
   localparam int TYPE_W      = 2;
   localparam int GAIN_W      = 32;
   localparam int FS_W        = 31;
   localparam int PROD_W      = GAIN_W + FS_W;
   localparam int WORD_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [MAG_W-1:0] MAG_MAX = 23'd8388607;
   localparam logic [AMP_W-1:0] AMP_FULL = 17'd65536;
   localparam logic [FS_W-1:0] FS_S16 = 31'd32767;
   localparam logic [FS_W-1:0] FS_S24 = 31'd8388607;
   localparam logic [FS_W-1:0] FS_S32 = 31'd2147483647;

   localparam logic [PHASE_BITS-1:0] PHASE_RESET  = '0;
   localparam logic [STEP_W-1:0]     STEP_RESET   = '0;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 24'd48000;
   localparam logic [COUNT_W-1:0]    COUNT_RESET  = 4'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PHASE_STEP,
      CSR_PERIOD_FRAMES,
      CSR_AMPLITUDE,
      CSR_SAMPLE_TYPE,
      CSR_CHANNEL_COUNT
   } csr_index_type;

   typedef enum logic [TYPE_W-1:0] {
      ST_S16,
      ST_S24,
      ST_S24_LJ,
      ST_S32
   } pcm_format_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROM,
      BK_GAIN,
      BK_SCALE,
      BK_PACK,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      logic [STEP_W-1:0]   phase_step;
      logic [PERIOD_W-1:0] period_frames;
      logic [AMP_W-1:0]    amplitude;
      pcm_format_type      pcm_format;
      logic [COUNT_W-1:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic [TABLE_ADDR_BITS-1:0] table_idx;
   } qentry_type;

   typedef logic [MAG_W-1:0] qrom_type [0:QUARTER];

   // Quarter-wave sine magnitude in unsigned Q0.23 from an integer Taylor series in Q2.30.
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] r;
      longint      s;
      x  = (64'(j) * 64'd2 * PI_Q30 + 64'(HALF)) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      r = (64'(s) + 64'd64) >> 7;
      if (r > 64'(MAG_MAX)) begin
         r = 64'(MAG_MAX);
      end
      return r[MAG_W-1:0];
   endfunction

   function automatic qrom_type build_quarter_rom();
      qrom_type rom;
      for (int j = 0; j <= QUARTER; j++) begin
         rom[j] = quarter_sine(j);
      end
      return rom;
   endfunction

   localparam qrom_type QUARTER_ROM = build_quarter_rom();

endpackage

FILE: rtl/pstg_front.sv
// Front part: accepts frame requests, keeps the phase accumulator and frame counter.
module pstg_front import pstg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] frame_request, [7:1] zero
   input  cfg_type    cfg,
   input  logic       q_full,
   output qentry_type push
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PERIOD_W-1:0]   frame_ff, frame_in;
   logic [PERIOD_W-1:0]   period;
   logic                  take;
   logic                  wrap;

   always_comb begin
      req_tready = !q_full;
      take       = req_tvalid && !q_full && req_tdata[0] && (cfg.channel_count != '0);
      period     = (cfg.period_frames == '0) ? PERIOD_W'(1) : cfg.period_frames;
      wrap       = ({1'b0, frame_ff} + (PERIOD_W + 1)'(1)) >= {1'b0, period};
      push.valid     = take;
      push.table_idx = phase_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      phase_in = phase_ff;
      frame_in = frame_ff;
      if (take) begin
         if (wrap) begin
            phase_in = '0;
            frame_in = '0;
         end else begin
            phase_in = phase_ff + PHASE_BITS'(cfg.phase_step);
            frame_in = frame_ff + PERIOD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RESET;
         frame_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         frame_ff <= frame_in;
      end
   end

endmodule

FILE: rtl/pstg_queue.sv
// Short queue of table indexes between the front and back parts.
module pstg_queue import pstg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  qentry_type push,
   output logic       q_full,
   input  logic       pop,
   output qentry_type head
);

   logic [TABLE_ADDR_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]            count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   always_comb begin
      q_full         = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      head.valid     = (count_ff != '0);
      head.table_idx = entry_ff[rd_ptr_ff];
      do_push        = push.valid && !q_full;
      do_pop         = pop && head.valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.table_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/pstg_back.sv
// Back part: sine table lookup, gain and full-scale multiply, packing and channel output.
module pstg_back import pstg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qentry_type  head,
   output logic        pop,
   input  cfg_type     cfg,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] sample_word, [34:32] byte_count,
                                    // [37:35] channel_index, [39:38] zero
   output logic        rsp_tlast
);

   bk_state_type          state_ff, state_in;
   logic [ROM_ADDR_W-1:0] rom_addr_ff, rom_addr_in;
   logic                  neg_ff, neg_in;
   logic [MAG_W-1:0]      rom_data_ff;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [CH_W-1:0]       chan_ff, chan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [2:0]            rsp_bytes_ff, rsp_bytes_in;
   logic [2:0]            rsp_chan_ff, rsp_chan_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [ROM_ADDR_W-1:0] fold_idx;
   logic [AMP_W-1:0]      amp_sat;
   logic [FS_W-1:0]       fs_value;
   logic [2:0]            byte_count;
   logic [CH_W-1:0]       last_idx;
   logic [WORD_W-1:0]     mag;
   logic [WORD_W-1:0]     signed_word;
   logic                  out_free;
   logic                  is_last;

   always_comb begin
      fold_idx = head.table_idx[ROM_ADDR_W-1:0];
      if (int'(fold_idx) > QUARTER) begin
         fold_idx = ROM_ADDR_W'(HALF - int'(fold_idx));
      end
      amp_sat = (cfg.amplitude > AMP_FULL) ? AMP_FULL : cfg.amplitude;
      unique case (cfg.pcm_format)
         ST_S16: begin
            fs_value   = FS_S16;
            byte_count = 3'd2;
         end
         ST_S24: begin
            fs_value   = FS_S24;
            byte_count = 3'd3;
         end
         ST_S24_LJ: begin
            fs_value   = FS_S24;
            byte_count = 3'd4;
         end
         default: begin
            fs_value   = FS_S32;
            byte_count = 3'd4;
         end
      endcase
      if (int'(cfg.channel_count) > MAX_CHANNELS) begin
         last_idx = CH_W'(MAX_CHANNELS - 1);
      end else begin
         last_idx = CH_W'(cfg.channel_count - COUNT_W'(1));
      end
      mag         = WORD_W'((prod_ff + PROD_W'(64'd1 << 30)) >> 31);
      signed_word = neg_ff ? (WORD_W'(0) - mag) : mag;
      out_free    = !rsp_valid_ff || rsp_tready;
      is_last     = (chan_ff == last_idx);

      state_in     = state_ff;
      rom_addr_in  = rom_addr_ff;
      neg_in       = neg_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      word_in      = word_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop         = 1'b1;
               rom_addr_in = fold_idx;
               neg_in      = head.table_idx[TABLE_ADDR_BITS-1];
               state_in    = BK_ROM;
            end
         end
         BK_ROM: begin
            state_in = BK_GAIN;
         end
         BK_GAIN: begin
            gain_in  = GAIN_W'((40'(rom_data_ff) * 40'(amp_sat) + 40'd128) >> 8);
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            prod_in  = PROD_W'(gain_ff) * PROD_W'(fs_value);
            state_in = BK_PACK;
         end
         BK_PACK: begin
            unique case (cfg.pcm_format)
               ST_S16:    word_in = {16'b0, signed_word[15:0]};
               ST_S24:    word_in = {8'b0, signed_word[23:0]};
               ST_S24_LJ: word_in = {signed_word[23:0], 8'b0};
               default:   word_in = signed_word;
            endcase
            chan_in  = '0;
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_ff;
               rsp_bytes_in = byte_count;
               rsp_chan_in  = 3'(chan_ff);
               rsp_last_in  = is_last;
               if (is_last) begin
                  state_in = BK_IDLE;
               end else begin
                  chan_in = chan_ff + CH_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {2'b0, rsp_chan_ff, rsp_bytes_ff, rsp_word_ff};
      rsp_tlast  = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= QUARTER_ROM[rom_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rom_addr_ff  <= rom_addr_in;
      neg_ff       <= neg_in;
      gain_ff      <= gain_in;
      prod_ff      <= prod_in;
      word_ff      <= word_in;
      chan_ff      <= chan_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

FILE: rtl/pcm_sine_tone_generator.sv
// PCM sine tone generator top level: configuration registers and the front, queue and back parts.
//
// Each item on the req_ channel with frame_request set asks for one PCM frame of a sine
// tone. The block answers with one item per channel on the rsp_ channel, all carrying the
// same packed sample word, with tlast on the final channel. A request with frame_request
// clear, or with channel_count zero, is taken and gives no result.
// The front part takes a request and updates the phase accumulator and frame
// counter; a two-entry queue holds the table indexes of pending frames. The back part runs
// each frame through a table read, the gain multiply, the full-scale multiply and packing,
// then sends the channels one per cycle from an output register while the receiver accepts them.
// A request waits in the queue; the back part then steps its frame through the ROM, GAIN, SCALE,
// PACK and EMIT states and takes the next frame only after the last channel, so the sustained
// frame rate is set by the back part's multiply sequence and channel output.
// Reset clears the phase and frame counter, empties the queue and output register, and
// loads the register defaults. When the receiver stalls, the output register holds its
// item, the back part waits, the queue fills, and req_tready falls. The user must write the
// registers with csr_we, csr_addr and csr_wdata only while idle; the block does not enforce it.
module pcm_sine_tone_generator import pstg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] frame_request, [7:1] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [31:0] sample_word, [34:32] byte_count,
                                              // [37:35] channel_index, [39:38] zero
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   qentry_type push;
   qentry_type head;
   logic       q_full;
   logic       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PHASE_STEP:    cfg_in.phase_step    = csr_wdata[STEP_W-1:0];
            CSR_PERIOD_FRAMES: cfg_in.period_frames = csr_wdata[PERIOD_W-1:0];
            CSR_AMPLITUDE:     cfg_in.amplitude     = csr_wdata[AMP_W-1:0];
            CSR_SAMPLE_TYPE:   cfg_in.pcm_format    = pcm_format_type'(csr_wdata[TYPE_W-1:0]);
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step    <= STEP_RESET;
         cfg_ff.period_frames <= PERIOD_RESET;
         cfg_ff.amplitude     <= AMP_FULL;
         cfg_ff.pcm_format    <= ST_S16;
         cfg_ff.channel_count <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pstg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push)
   );

   pstg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_full (q_full),
      .pop    (pop),
      .head   (head)
   );

   pstg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
